FILE: sv/tlsi_pkg.sv
package tlsi_pkg;

  localparam int OPCODE_W = 3;
  localparam int CHAR_W = 16;
  localparam int ENTRY_W = 20;
  localparam int QOFF_W = 21;
  localparam int LIDX_W = 12;
  localparam int FOUND_W = 11;
  localparam int START_W = 20;
  localparam int CHARS_W = 20;
  localparam int TOTAL_W = 11;
  localparam int LENGTH_W = 20;

  localparam int MAX_LINES_DEF = 1024;
  localparam int OFFSET_BITS_DEF = 20;

  localparam logic [CHAR_W-1:0] CHAR_CR = 16'd13;
  localparam logic [CHAR_W-1:0] CHAR_LF = 16'd10;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR = 3'd0,
    OP_TEXT  = 3'd1,
    OP_ENTRY = 3'd2,
    OP_FIND  = 3'd3,
    OP_INFO  = 3'd4
  } op_t;

endpackage

FILE: sv/tlsi_table.sv
module tlsi_table #(
  parameter int DEPTH = tlsi_pkg::MAX_LINES_DEF,
  parameter int WIDTH = tlsi_pkg::OFFSET_BITS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_raw;
  logic             rd_zero;

  // entry 0 is always zero and never stored
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
      rd_zero <= (rd_addr == '0);
    end
  end

  assign rd_data = rd_zero ? '0 : rd_raw;

endmodule

FILE: sv/tlsi_query.sv
module tlsi_query #(
  parameter int MAX_LINES = tlsi_pkg::MAX_LINES_DEF,
  parameter int OFFSET_BITS = tlsi_pkg::OFFSET_BITS_DEF,
  localparam int AW = $clog2(MAX_LINES),
  localparam int LW = $clog2(MAX_LINES + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                go_find,
  input  logic                                go_info,
  input  logic signed [tlsi_pkg::QOFF_W-1:0]  query_offset,
  input  logic signed [tlsi_pkg::LIDX_W-1:0]  line_index,
  input  logic [LW-1:0]                       line_total,
  input  logic [OFFSET_BITS-1:0]              text_total,
  input  logic                                overflow_flag,
  output logic                                rd_en,
  output logic [AW-1:0]                       rd_addr,
  input  logic [OFFSET_BITS-1:0]              rd_data,
  output logic                                busy,
  output logic                                done,
  output logic [tlsi_pkg::FOUND_W-1:0]        found_line_number,
  output logic [tlsi_pkg::START_W-1:0]        line_start,
  output logic [tlsi_pkg::CHARS_W-1:0]        line_chars,
  output logic [tlsi_pkg::TOTAL_W-1:0]        lines_total,
  output logic [tlsi_pkg::LENGTH_W-1:0]       length_total,
  output logic                                overflowed
);

  localparam int CW = (OFFSET_BITS > 20) ? OFFSET_BITS : 20;
  localparam int IW = (LW > 11) ? LW : 11;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_ISSUE   = 6'b000010,
    S_CMP     = 6'b000100,
    S_INFO_RD = 6'b001000,
    S_INFO_ST = 6'b010000,
    S_INFO_NX = 6'b100000
  } state_t;

  state_t state;

  logic [OFFSET_BITS-1:0] target;
  logic [LW-1:0]          lo;
  logic [LW-1:0]          hix;
  logic [AW-1:0]          best;
  logic [AW-1:0]          mid_q;
  logic [AW-1:0]          idx;
  logic [OFFSET_BITS-1:0] lstart;

  logic [LW:0]            mid_sum;
  logic [AW-1:0]          mid;
  logic                   has_next;
  logic [OFFSET_BITS-1:0] target_c;
  logic [AW-1:0]          idx_c;
  logic [OFFSET_BITS-1:0] cur_start;
  logic [OFFSET_BITS-1:0] nxt_start;
  logic [OFFSET_BITS-1:0] gap;
  logic [OFFSET_BITS-1:0] lchars_c;
  logic [LW-1:0]          last_line;

  assign busy = (state != S_IDLE);
  assign mid_sum = {1'b0, lo} + {1'b0, hix};
  assign mid = AW'(mid_sum >> 1);
  assign has_next = (LW'(idx) + LW'(1)) < line_total;
  assign last_line = line_total - LW'(1);

  // clamp the query fields at acceptance
  always_comb begin
    if (query_offset[tlsi_pkg::QOFF_W-1]) begin
      target_c = '0;
    end else if (CW'(query_offset[tlsi_pkg::QOFF_W-2:0]) < CW'(text_total)) begin
      target_c = OFFSET_BITS'(query_offset[tlsi_pkg::QOFF_W-2:0]);
    end else begin
      target_c = text_total;
    end
    if (line_index[tlsi_pkg::LIDX_W-1]) begin
      idx_c = '0;
    end else if (IW'(line_index[tlsi_pkg::LIDX_W-2:0]) < IW'(last_line)) begin
      idx_c = AW'(line_index[tlsi_pkg::LIDX_W-2:0]);
    end else begin
      idx_c = AW'(last_line);
    end
  end

  always_comb begin
    rd_en = 1'b0;
    rd_addr = mid;
    unique case (state)
      S_ISSUE: begin
        rd_en = (lo < hix);
        rd_addr = mid;
      end
      S_INFO_RD: begin
        rd_en = 1'b1;
        rd_addr = idx;
      end
      S_INFO_ST: begin
        rd_en = has_next;
        rd_addr = AW'(idx + AW'(1));
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // character count of the line, newline excluded
  always_comb begin
    cur_start = (state == S_INFO_ST) ? rd_data : lstart;
    nxt_start = (state == S_INFO_NX) ? rd_data : text_total;
    gap = (nxt_start > cur_start) ? (nxt_start - cur_start) : '0;
    lchars_c = ((state == S_INFO_NX) && (gap != '0)) ? (gap - OFFSET_BITS'(1)) : gap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (go_find) begin
            target <= target_c;
            lo <= LW'(1);
            hix <= line_total;
            best <= '0;
            state <= S_ISSUE;
          end else if (go_info) begin
            idx <= idx_c;
            state <= S_INFO_RD;
          end
        end
        S_ISSUE: begin
          if (lo < hix) begin
            mid_q <= mid;
            state <= S_CMP;
          end else begin
            found_line_number <= tlsi_pkg::FOUND_W'(LW'(best) + LW'(1));
            line_start <= '0;
            line_chars <= '0;
            lines_total <= tlsi_pkg::TOTAL_W'(line_total);
            length_total <= tlsi_pkg::LENGTH_W'(text_total);
            overflowed <= overflow_flag;
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_CMP: begin
          if (rd_data <= target) begin
            best <= mid_q;
            lo <= LW'(mid_q) + LW'(1);
          end else begin
            hix <= LW'(mid_q);
          end
          state <= S_ISSUE;
        end
        S_INFO_RD: begin
          state <= S_INFO_ST;
        end
        S_INFO_ST: begin
          lstart <= rd_data;
          if (has_next) begin
            state <= S_INFO_NX;
          end else begin
            found_line_number <= tlsi_pkg::FOUND_W'(LW'(idx) + LW'(1));
            line_start <= tlsi_pkg::START_W'(rd_data);
            line_chars <= tlsi_pkg::CHARS_W'(lchars_c);
            lines_total <= tlsi_pkg::TOTAL_W'(line_total);
            length_total <= tlsi_pkg::LENGTH_W'(text_total);
            overflowed <= overflow_flag;
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_INFO_NX: begin
          found_line_number <= tlsi_pkg::FOUND_W'(LW'(idx) + LW'(1));
          line_start <= tlsi_pkg::START_W'(lstart);
          line_chars <= tlsi_pkg::CHARS_W'(lchars_c);
          lines_total <= tlsi_pkg::TOTAL_W'(line_total);
          length_total <= tlsi_pkg::LENGTH_W'(text_total);
          overflowed <= overflow_flag;
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> (state == S_IDLE))
    else $error("result strobe while a query is running");
  a_cmp_after_issue: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> ($past(state) == S_ISSUE))
    else $error("compare without a table read");
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE) |-> (lo <= hix))
    else $error("search bounds crossed");
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (LW'(rd_addr) < line_total))
    else $error("table read beyond written entries");
`endif

endmodule

FILE: sv/text_line_start_index_core.sv
// line start index over a stream of utf-16 text units or line entries
//
// one input channel, command style: an item transfers on a rising edge with
// start high and busy low. opcode selects clear, text unit, line entry,
// offset-to-line query or line info query.
// build items (clear, text unit, line entry) leave busy low, so while no
// query runs one can transfer every cycle.
// queries raise busy until their result is out. offset-to-line runs a binary
// search over the start table, each probe an issue state and a compare state
// through the table's read port. line info makes one or two table reads.
// each result sits on the result ports for exactly one cycle with done high;
// there is no result back pressure. a new item may transfer in that cycle.
// reset (rst, synchronous) leaves one empty line, zero length and no
// overflow; entry 0 of the table is built in as zero, so no clearing pass.
module text_line_start_index_core #(
  parameter int MAX_LINES = tlsi_pkg::MAX_LINES_DEF,
  parameter int OFFSET_BITS = tlsi_pkg::OFFSET_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [tlsi_pkg::OPCODE_W-1:0]       opcode,
  input  logic [tlsi_pkg::CHAR_W-1:0]         char_unit,
  input  logic [tlsi_pkg::ENTRY_W-1:0]        entry_chars,
  input  logic signed [tlsi_pkg::QOFF_W-1:0]  query_offset,
  input  logic signed [tlsi_pkg::LIDX_W-1:0]  line_index,
  output logic                                done,
  output logic [tlsi_pkg::FOUND_W-1:0]        found_line_number,
  output logic [tlsi_pkg::START_W-1:0]        line_start,
  output logic [tlsi_pkg::CHARS_W-1:0]        line_chars,
  output logic [tlsi_pkg::TOTAL_W-1:0]        lines_total,
  output logic [tlsi_pkg::LENGTH_W-1:0]       length_total,
  output logic                                overflowed
);

  localparam int AW = $clog2(MAX_LINES);
  localparam int LW = $clog2(MAX_LINES + 1);
  localparam int SW = ((OFFSET_BITS > tlsi_pkg::ENTRY_W) ? OFFSET_BITS : tlsi_pkg::ENTRY_W) + 1;
  localparam logic [SW-1:0] LEN_MAX = SW'((64'd1 << OFFSET_BITS) - 64'd1);

  logic [LW-1:0]          line_total;
  logic [LW-1:0]          line_total_next;
  logic [OFFSET_BITS-1:0] text_total;
  logic [OFFSET_BITS-1:0] text_total_next;
  logic                   cr_pending;
  logic                   cr_pending_next;
  logic                   entry_seen;
  logic                   entry_seen_next;
  logic                   overflow_flag;
  logic                   overflow_flag_next;

  logic                   accept;
  logic                   newline;
  logic                   wr_en;
  logic [SW-1:0]          sum1;
  logic [SW-1:0]          sum2;
  logic                   sat1;
  logic                   sat2;
  logic [OFFSET_BITS-1:0] t1;
  logic [OFFSET_BITS-1:0] t2;
  logic [OFFSET_BITS-1:0] base;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [OFFSET_BITS-1:0] rd_data;

  assign accept = start && !busy;

  // saturating length growth
  always_comb begin
    sum1 = SW'(text_total) + SW'(1);
    sat1 = (sum1 > LEN_MAX);
    t1 = sat1 ? OFFSET_BITS'(LEN_MAX) : OFFSET_BITS'(sum1);
    base = entry_seen ? t1 : text_total;
    sum2 = SW'(base) + SW'(entry_chars);
    sat2 = (sum2 > LEN_MAX);
    t2 = sat2 ? OFFSET_BITS'(LEN_MAX) : OFFSET_BITS'(sum2);
  end

  always_comb begin
    line_total_next = line_total;
    text_total_next = text_total;
    cr_pending_next = cr_pending;
    entry_seen_next = entry_seen;
    overflow_flag_next = overflow_flag;
    newline = 1'b0;
    wr_en = 1'b0;
    if (accept) begin
      unique case (opcode)
        tlsi_pkg::OP_CLEAR: begin
          line_total_next = LW'(1);
          text_total_next = '0;
          cr_pending_next = 1'b0;
          entry_seen_next = 1'b0;
          overflow_flag_next = 1'b0;
        end
        tlsi_pkg::OP_TEXT: begin
          if (char_unit == tlsi_pkg::CHAR_CR) begin
            newline = 1'b1;
            text_total_next = t1;
            overflow_flag_next = overflow_flag || sat1;
            cr_pending_next = 1'b1;
          end else if (char_unit == tlsi_pkg::CHAR_LF) begin
            if (!cr_pending) begin
              newline = 1'b1;
              text_total_next = t1;
              overflow_flag_next = overflow_flag || sat1;
            end
            cr_pending_next = 1'b0;
          end else begin
            text_total_next = t1;
            overflow_flag_next = overflow_flag || sat1;
            cr_pending_next = 1'b0;
          end
        end
        tlsi_pkg::OP_ENTRY: begin
          newline = entry_seen;
          text_total_next = t2;
          overflow_flag_next = overflow_flag || (entry_seen && sat1) || sat2;
          entry_seen_next = 1'b1;
          cr_pending_next = 1'b0;
        end
        default: begin
          newline = 1'b0;
        end
      endcase
      if (newline) begin
        if (line_total < LW'(MAX_LINES)) begin
          wr_en = 1'b1;
          line_total_next = line_total + LW'(1);
        end else begin
          overflow_flag_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_total <= LW'(1);
      text_total <= '0;
      cr_pending <= 1'b0;
      entry_seen <= 1'b0;
      overflow_flag <= 1'b0;
    end else begin
      line_total <= line_total_next;
      text_total <= text_total_next;
      cr_pending <= cr_pending_next;
      entry_seen <= entry_seen_next;
      overflow_flag <= overflow_flag_next;
    end
  end

  tlsi_table #(
    .DEPTH (MAX_LINES),
    .WIDTH (OFFSET_BITS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (line_total[AW-1:0]),
    .wr_data (t1),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tlsi_query #(
    .MAX_LINES   (MAX_LINES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_query (
    .clk               (clk),
    .rst               (rst),
    .go_find           (accept && (opcode == tlsi_pkg::OP_FIND)),
    .go_info           (accept && (opcode == tlsi_pkg::OP_INFO)),
    .query_offset      (query_offset),
    .line_index        (line_index),
    .line_total        (line_total),
    .text_total        (text_total),
    .overflow_flag     (overflow_flag),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .busy              (busy),
    .done              (done),
    .found_line_number (found_line_number),
    .line_start        (line_start),
    .line_chars        (line_chars),
    .lines_total       (lines_total),
    .length_total      (length_total),
    .overflowed        (overflowed)
  );

endmodule

FILE: tb/text_line_start_index_core_tb.sv
`timescale 1ns / 100ps

module text_line_start_index_core_tb;

  localparam int MAX_LINES = tlsi_pkg::MAX_LINES_DEF;
  localparam int OFFSET_BITS = tlsi_pkg::OFFSET_BITS_DEF;
  localparam longint LEN_MAX = (longint'(1) << OFFSET_BITS) - 1;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRINT_CAP = 50;

  typedef struct {
    logic [tlsi_pkg::FOUND_W-1:0]  found;
    logic [tlsi_pkg::START_W-1:0]  lstart;
    logic [tlsi_pkg::CHARS_W-1:0]  lchars;
    logic [tlsi_pkg::TOTAL_W-1:0]  lines;
    logic [tlsi_pkg::LENGTH_W-1:0] length;
    logic                          ovf;
  } line_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [tlsi_pkg::OPCODE_W-1:0] opcode = '0;
  logic [tlsi_pkg::CHAR_W-1:0] char_unit = '0;
  logic [tlsi_pkg::ENTRY_W-1:0] entry_chars = '0;
  logic signed [tlsi_pkg::QOFF_W-1:0] query_offset = '0;
  logic signed [tlsi_pkg::LIDX_W-1:0] line_index = '0;
  logic done;
  logic [tlsi_pkg::FOUND_W-1:0] found_line_number;
  logic [tlsi_pkg::START_W-1:0] line_start;
  logic [tlsi_pkg::CHARS_W-1:0] line_chars;
  logic [tlsi_pkg::TOTAL_W-1:0] lines_total;
  logic [tlsi_pkg::LENGTH_W-1:0] length_total;
  logic overflowed;

  logic [tlsi_pkg::START_W-1:0] model_starts [MAX_LINES];
  int model_lines;
  longint model_len;
  bit model_cr;
  bit model_entry_seen;
  bit model_ovf;

  line_answer_t pending_answers [$];
  line_answer_t oldest_answer;
  int sender_idle_pct = 0;
  int items_sent = 0;
  int queries_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;

  text_line_start_index_core #(
    .MAX_LINES(MAX_LINES),
    .OFFSET_BITS(OFFSET_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .char_unit(char_unit),
    .entry_chars(entry_chars),
    .query_offset(query_offset),
    .line_index(line_index),
    .done(done),
    .found_line_number(found_line_number),
    .line_start(line_start),
    .line_chars(line_chars),
    .lines_total(lines_total),
    .length_total(length_total),
    .overflowed(overflowed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void index_clear();
    model_lines = 1;
    model_len = 0;
    model_cr = 1'b0;
    model_entry_seen = 1'b0;
    model_ovf = 1'b0;
    model_starts[0] = '0;
  endfunction

  function automatic void index_grow(longint amount);
    model_len = model_len + amount;
    if (model_len > LEN_MAX) begin
      model_len = LEN_MAX;
      model_ovf = 1'b1;
    end
  endfunction

  function automatic void index_newline();
    index_grow(1);
    if (model_lines < MAX_LINES) begin
      model_starts[model_lines] = tlsi_pkg::START_W'(model_len);
      model_lines++;
    end else begin
      model_ovf = 1'b1;
    end
  endfunction

  // updates the line index and queues the answer of a query
  function automatic void line_index_step(logic [tlsi_pkg::OPCODE_W-1:0] op,
                                          logic [tlsi_pkg::CHAR_W-1:0] cu,
                                          logic [tlsi_pkg::ENTRY_W-1:0] ec,
                                          logic signed [tlsi_pkg::QOFF_W-1:0] qo,
                                          logic signed [tlsi_pkg::LIDX_W-1:0] li);
    line_answer_t ans;
    longint qv, target, lv, st, nxt;
    int lo, hi, mid, best, idx;
    bit has_next;
    ans = '{default: '0};
    case (op)
      tlsi_pkg::OP_CLEAR: index_clear();
      tlsi_pkg::OP_TEXT: begin
        if (cu == tlsi_pkg::CHAR_CR) begin
          index_newline();
          model_cr = 1'b1;
        end else if (cu == tlsi_pkg::CHAR_LF) begin
          if (!model_cr) index_newline();
          model_cr = 1'b0;
        end else begin
          index_grow(1);
          model_cr = 1'b0;
        end
      end
      tlsi_pkg::OP_ENTRY: begin
        if (model_entry_seen) index_newline();
        index_grow(longint'(ec));
        model_entry_seen = 1'b1;
        model_cr = 1'b0;
      end
      tlsi_pkg::OP_FIND: begin
        qv = qo;
        if (qv < 0) target = 0;
        else if (qv < model_len) target = qv;
        else target = model_len;
        lo = 0;
        hi = model_lines - 1;
        best = 0;
        while (lo <= hi) begin
          mid = lo + (hi - lo) / 2;
          if (longint'(model_starts[mid]) <= target) begin
            best = mid;
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
        ans.found = tlsi_pkg::FOUND_W'(best + 1);
      end
      tlsi_pkg::OP_INFO: begin
        lv = li;
        if (lv < 0) idx = 0;
        else if (lv < model_lines - 1) idx = int'(lv);
        else idx = model_lines - 1;
        st = model_starts[idx];
        has_next = (idx + 1 < model_lines);
        nxt = has_next ? longint'(model_starts[idx + 1]) : model_len;
        if (nxt > st) ans.lchars = tlsi_pkg::CHARS_W'(has_next ? nxt - st - 1 : nxt - st);
        ans.lstart = tlsi_pkg::START_W'(st);
        ans.found = tlsi_pkg::FOUND_W'(idx + 1);
      end
      default: ;
    endcase
    if (op == tlsi_pkg::OP_FIND || op == tlsi_pkg::OP_INFO) begin
      ans.lines = tlsi_pkg::TOTAL_W'(model_lines);
      ans.length = tlsi_pkg::LENGTH_W'(model_len);
      ans.ovf = model_ovf;
      pending_answers = {pending_answers, ans};
      queries_sent++;
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic send_item(input logic [tlsi_pkg::OPCODE_W-1:0] op,
                           input logic [tlsi_pkg::CHAR_W-1:0] cu,
                           input logic [tlsi_pkg::ENTRY_W-1:0] ec,
                           input logic signed [tlsi_pkg::QOFF_W-1:0] qo,
                           input logic signed [tlsi_pkg::LIDX_W-1:0] li);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    opcode <= op;
    char_unit <= cu;
    entry_chars <= ec;
    query_offset <= qo;
    line_index <= li;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    line_index_step(op, cu, ec, qo, li);
    items_sent++;
  endtask

  task automatic send_clear();
    send_item(tlsi_pkg::OP_CLEAR, tlsi_pkg::CHAR_W'($urandom), tlsi_pkg::ENTRY_W'($urandom),
              tlsi_pkg::QOFF_W'($urandom), tlsi_pkg::LIDX_W'($urandom));
  endtask

  task automatic send_text(input logic [tlsi_pkg::CHAR_W-1:0] cu);
    send_item(tlsi_pkg::OP_TEXT, cu, tlsi_pkg::ENTRY_W'($urandom), tlsi_pkg::QOFF_W'($urandom),
              tlsi_pkg::LIDX_W'($urandom));
  endtask

  task automatic send_entry(input logic [tlsi_pkg::ENTRY_W-1:0] ec);
    send_item(tlsi_pkg::OP_ENTRY, tlsi_pkg::CHAR_W'($urandom), ec, tlsi_pkg::QOFF_W'($urandom),
              tlsi_pkg::LIDX_W'($urandom));
  endtask

  task automatic send_find(input logic signed [tlsi_pkg::QOFF_W-1:0] qo);
    send_item(tlsi_pkg::OP_FIND, tlsi_pkg::CHAR_W'($urandom), tlsi_pkg::ENTRY_W'($urandom), qo,
              tlsi_pkg::LIDX_W'($urandom));
  endtask

  task automatic send_info(input logic signed [tlsi_pkg::LIDX_W-1:0] li);
    send_item(tlsi_pkg::OP_INFO, tlsi_pkg::CHAR_W'($urandom), tlsi_pkg::ENTRY_W'($urandom),
              tlsi_pkg::QOFF_W'($urandom), li);
  endtask

  task automatic send_unknown(input logic [tlsi_pkg::OPCODE_W-1:0] op);
    send_item(op, tlsi_pkg::CHAR_W'($urandom), tlsi_pkg::ENTRY_W'($urandom),
              tlsi_pkg::QOFF_W'($urandom), tlsi_pkg::LIDX_W'($urandom));
  endtask

  task automatic test_reset_and_unknown_ops();
    send_find(0);
    for (int k = tlsi_pkg::OP_INFO + 1; k < 2 ** tlsi_pkg::OPCODE_W; k++)
      send_unknown(tlsi_pkg::OPCODE_W'(k));
    send_info(0);
  endtask

  task automatic test_text_units();
    send_clear();
    send_text(16'h0041);
    send_text(16'hFFFF);
    send_text(tlsi_pkg::CHAR_CR);
    send_text(tlsi_pkg::CHAR_LF);
    send_text(tlsi_pkg::CHAR_LF);
    send_text(tlsi_pkg::CHAR_CR);
    send_text(tlsi_pkg::CHAR_CR);
    send_text(16'h0000);
    send_find(tlsi_pkg::QOFF_W'(-(2 ** (tlsi_pkg::QOFF_W - 1))));
    send_find(3);
    send_find(tlsi_pkg::QOFF_W'(2 ** (tlsi_pkg::QOFF_W - 1) - 1));
    send_info(tlsi_pkg::LIDX_W'(-(2 ** (tlsi_pkg::LIDX_W - 1))));
    send_info(1);
    send_info(tlsi_pkg::LIDX_W'(2 ** (tlsi_pkg::LIDX_W - 1) - 1));
  endtask

  task automatic test_line_entries();
    send_clear();
    send_entry(5);
    send_entry(0);
    send_text(tlsi_pkg::CHAR_CR);
    send_entry(3);
    send_info(1);
    send_info(3);
    send_find(6);
  endtask

  task automatic test_length_saturation();
    send_clear();
    send_entry('1);
    send_entry('1);
    send_text(16'h0062);
    send_find(tlsi_pkg::QOFF_W'(2 ** (tlsi_pkg::QOFF_W - 1) - 1));
    send_info(1);
  endtask

  task automatic test_table_full();
    send_clear();
    for (int n = 0; n < MAX_LINES + 6; n++) send_entry(tlsi_pkg::ENTRY_W'($urandom_range(3)));
    send_text(tlsi_pkg::CHAR_CR);
    send_info(tlsi_pkg::LIDX_W'(2 ** (tlsi_pkg::LIDX_W - 1) - 1));
    send_info(tlsi_pkg::LIDX_W'(MAX_LINES - 2));
    send_find(tlsi_pkg::QOFF_W'(2 ** (tlsi_pkg::QOFF_W - 1) - 1));
    for (int n = 0; n < 10; n++)
      send_find(tlsi_pkg::QOFF_W'($urandom_range(int'(model_len))));
    for (int n = 0; n < 4; n++) send_info(tlsi_pkg::LIDX_W'($urandom_range(MAX_LINES - 1)));
  endtask

  task automatic send_random_build();
    int r;
    r = $urandom_range(99);
    if (r < 40) begin
      if ($urandom_range(9) == 0) send_text(tlsi_pkg::CHAR_W'($urandom));
      else send_text(tlsi_pkg::CHAR_W'($urandom_range(16'h7E, 16'h20)));
    end else if (r < 55) begin
      send_text(tlsi_pkg::CHAR_CR);
    end else if (r < 65) begin
      send_text(tlsi_pkg::CHAR_LF);
    end else if (r < 72) begin
      send_text(tlsi_pkg::CHAR_CR);
      send_text(tlsi_pkg::CHAR_LF);
    end else if (r < 94) begin
      if ($urandom_range(49) == 0) send_entry(tlsi_pkg::ENTRY_W'($urandom));
      else send_entry(tlsi_pkg::ENTRY_W'($urandom_range(20)));
    end else if (r < 97) begin
      send_unknown(tlsi_pkg::OPCODE_W'($urandom_range(2 ** tlsi_pkg::OPCODE_W - 1,
                                                       tlsi_pkg::OP_INFO + 1)));
    end else begin
      send_clear();
    end
  endtask

  task automatic send_random_query();
    if ($urandom_range(1)) begin
      if ($urandom_range(9) < 7)
        send_find(tlsi_pkg::QOFF_W'(int'($urandom_range(int'(model_len) + 4)) - 2));
      else send_find(tlsi_pkg::QOFF_W'($urandom));
    end else begin
      if ($urandom_range(9) < 7)
        send_info(tlsi_pkg::LIDX_W'(int'($urandom_range(model_lines + 3)) - 2));
      else send_info(tlsi_pkg::LIDX_W'($urandom));
    end
  endtask

  task automatic test_random(input int idle_pct, input int count);
    int target_items;
    target_items = items_sent + count;
    sender_idle_pct = idle_pct;
    while (items_sent < target_items) begin
      if ($urandom_range(9) == 0) send_clear();
      repeat ($urandom_range(40, 1)) send_random_build();
      repeat ($urandom_range(8, 1)) send_random_query();
    end
    sender_idle_pct = 0;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result with no query waiting");
      end else begin
        oldest_answer = pending_answers.pop_front();
        results_checked++;
        if (found_line_number !== oldest_answer.found)
          report_mismatch($sformatf("found_line_number %0d, want %0d",
                                    found_line_number, oldest_answer.found));
        if (line_start !== oldest_answer.lstart)
          report_mismatch($sformatf("line_start %0d, want %0d",
                                    line_start, oldest_answer.lstart));
        if (line_chars !== oldest_answer.lchars)
          report_mismatch($sformatf("line_chars %0d, want %0d",
                                    line_chars, oldest_answer.lchars));
        if (lines_total !== oldest_answer.lines)
          report_mismatch($sformatf("lines_total %0d, want %0d",
                                    lines_total, oldest_answer.lines));
        if (length_total !== oldest_answer.length)
          report_mismatch($sformatf("length_total %0d, want %0d",
                                    length_total, oldest_answer.length));
        if (overflowed !== oldest_answer.ovf)
          report_mismatch($sformatf("overflowed %0b, want %0b",
                                    overflowed, oldest_answer.ovf));
      end
    end
  end

  initial begin
    index_clear();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_and_unknown_ops();
    test_text_units();
    test_line_entries();
    test_length_saturation();
    test_table_full();
    // results cannot be held off, so only the sender idles
    test_random(0, 100);
    test_random(46, 100);
    test_random(16, 100);
    drain_results();
    $display("sent %0d items (%0d queries), checked %0d results, %0d mismatches",
             items_sent, queries_sent, results_checked, mismatch_count);
    $display("covered crlf and lone cr, line entries, clamps, saturation, full table");
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("text_line_start_index_core_tb: PASS");
    end else begin
      $display("text_line_start_index_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", pending_answers.size());
    $display("text_line_start_index_core_tb: FAIL");
    $finish;
  end

endmodule
